// ----- rtl/swrl_pkg.sv -----
// ----------------------------------------------------------------------------
// swrl_pkg : shared types and constants of the sliding-log rate limiter
// Field widths, register indexes and reset values used by every file.
// ----------------------------------------------------------------------------
package swrl_pkg;

  // Field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WIN_W      = 31;
  localparam int unsigned MAXMSG_W   = 7;
  localparam int unsigned OCC_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGES = 2'd1;

  // Register reset values
  localparam logic [WIN_W-1:0]    WINDOW_RESET = 31'd1000;
  localparam logic [MAXMSG_W-1:0] MAXMSG_RESET = 7'd64;

  typedef logic [TIME_W-1:0] time_word_t;

endpackage

// ----- rtl/sliding_window_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter : sliding-log message rate limiter
// Keeps a ring of accepted arrival times, expires old ones and throttles
// requests once the limit within the window is reached.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request word, its
//   arrival_time in ticks. Output channel (out_valid / out_stall) returns one
//   word per request: throttled and the occupancy of the ring afterwards.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set
//   window_ticks (index 0) and max_messages (index 1); other indexes are
//   ignored. cfg_ready is high outside reset; write only while idle.
// Sequencing:
//   An accepted request passes through ST_CHECK, which pops stored times
//   that expire on it from the oldest end, and ST_DECIDE, which registers
//   the result; ST_CHECK is skipped on an empty ring. The expiry loop makes
//   one ring read and one age compare per cycle through a single compare
//   unit. in_stall stays high until the result is registered, so no new
//   request is taken before the last one is through.
// Reset:
//   rst empties the ring (head and count to zero) and restores the
//   registers to window 1000 and limit 64. Ring contents are not cleared.
// Stall:
//   The result waits in the output register while out_stall is high; a new
//   request can be accepted meanwhile, but its result is held back until the
//   register is free.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [swrl_pkg::TIME_W-1:0]         arrival_time,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                throttled,
  output logic [swrl_pkg::OCC_W-1:0]          occupancy,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned IW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned LW = (CW > swrl_pkg::MAXMSG_W) ? CW : swrl_pkg::MAXMSG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE
  } state_t;

  state_t state;

  logic [IW-1:0]                  ring_head;
  logic [CW-1:0]                  ring_count;
  logic [swrl_pkg::WIN_W-1:0]     window_ticks;
  logic [swrl_pkg::MAXMSG_W-1:0]  max_messages;
  swrl_pkg::time_word_t           now;

  logic                           in_accept;
  logic                           slot_free;
  logic [IW-1:0]                  head_inc;
  logic [IW:0]                    wr_sum;
  logic [IW-1:0]                  wr_addr;
  logic [IW-1:0]                  rd_addr;
  logic                           wr_en;
  swrl_pkg::time_word_t           rd_data;
  logic                           expired;
  logic [LW-1:0]                  limit;
  logic                           at_limit;
  logic [CW-1:0]                  count_plus;

  // Handshakes
  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // Ring index arithmetic
  assign head_inc = (ring_head == IW'(RING_DEPTH - 1)) ? '0 : ring_head + 1'b1;
  assign wr_sum   = (IW + 1)'(ring_head) + (IW + 1)'(ring_count);
  assign wr_addr  = (wr_sum >= (IW + 1)'(RING_DEPTH)) ?
                    IW'(wr_sum - (IW + 1)'(RING_DEPTH)) : IW'(wr_sum);

  // Read the head on acceptance, the next entry while popping
  assign rd_addr = (state == ST_CHECK) ? head_inc : ring_head;

  // Effective limit saturates at the ring depth
  assign limit = (LW'(max_messages) > LW'(RING_DEPTH)) ? LW'(RING_DEPTH) :
                 LW'(max_messages);
  assign at_limit   = LW'(ring_count) >= limit;
  assign count_plus = ring_count + 1'b1;
  assign wr_en      = (state == ST_DECIDE) && slot_free && !at_limit;

  swrl_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (now),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  swrl_age_cmp u_age (
    .now     (now),
    .stored  (rd_data),
    .window  (window_ticks),
    .expired (expired)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= swrl_pkg::WINDOW_RESET;
      max_messages <= swrl_pkg::MAXMSG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == swrl_pkg::REG_WINDOW_TICKS) begin
        window_ticks <= cfg_data[swrl_pkg::WIN_W-1:0];
      end else if (cfg_index == swrl_pkg::REG_MAX_MESSAGES) begin
        max_messages <= cfg_data[swrl_pkg::MAXMSG_W-1:0];
      end
    end
  end

  // Hold the request time
  always_ff @(posedge clk) begin
    if (in_accept) begin
      now <= arrival_time;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((state == ST_DECIDE) && slot_free) begin
      throttled <= at_limit;
      occupancy <= at_limit ? swrl_pkg::OCC_W'(ring_count) :
                              swrl_pkg::OCC_W'(count_plus);
    end
  end

  // Sequencer: expire from the oldest end, then decide and append
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ring_head  <= '0;
      ring_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Raise the result word from the decide step, hold it while stalled
      out_valid <= ((state == ST_DECIDE) && slot_free) || (out_valid && out_stall);
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= (ring_count == '0) ? ST_DECIDE : ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (expired) begin
            ring_head  <= head_inc;
            ring_count <= ring_count - 1'b1;
            if (ring_count == CW'(1)) begin
              state <= ST_DECIDE;
            end
          end else begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (slot_free) begin
            if (!at_limit) begin
              ring_count <= count_plus;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CW'(RING_DEPTH))
    else $error("ring count exceeds ring depth");

  a_check_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (ring_count != '0))
    else $error("expiry check on an empty ring");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DECIDE))
    else $error("result raised outside the decide step");

  a_no_store_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid) && throttled) |-> $stable(ring_count))
    else $error("throttled request changed the ring count");

endmodule

// ----- rtl/swrl_ring.sv -----
// ----------------------------------------------------------------------------
// swrl_ring : storage ring of accepted arrival times
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module swrl_ring #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  swrl_pkg::time_word_t             wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output swrl_pkg::time_word_t             rd_data
);

  swrl_pkg::time_word_t mem [DEPTH];

  // Write the appended arrival time
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read of the addressed entry: the oldest, or the next one while popping
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/swrl_age_cmp.sv -----
// ----------------------------------------------------------------------------
// swrl_age_cmp : age compare unit
// Takes the age of one stored time modulo 2^32 and flags it as expired when
// it is strictly greater than the window.
// ----------------------------------------------------------------------------
module swrl_age_cmp (
  input  swrl_pkg::time_word_t              now,
  input  swrl_pkg::time_word_t              stored,
  input  logic [swrl_pkg::WIN_W-1:0]        window,
  output logic                              expired
);

  swrl_pkg::time_word_t age;

  // Subtract with natural wrap, then compare against the zero-extended window
  assign age     = now - stored;
  assign expired = age > {1'b0, window};

endmodule

// ----- tb/swrl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_checker : result checker for the sliding-log rate limiter
// Watches the request, result and configuration channels, keeps its own
// copy of the arrival-time ring and register state, predicts the throttle
// decision and occupancy of every accepted request and compares each result
// word with the oldest prediction.
// ----------------------------------------------------------------------------
module swrl_checker #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [swrl_pkg::TIME_W-1:0]     arrival_time,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            throttled,
  input  logic [swrl_pkg::OCC_W-1:0]      occupancy,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct packed {
    logic                       throttled;
    logic [swrl_pkg::OCC_W-1:0] occupancy;
  } admission_t;

  // Shadow copy of the ring and the registers
  swrl_pkg::time_word_t          stamp_log [RING_DEPTH];
  int unsigned                   log_head;
  int unsigned                   log_count;
  logic [swrl_pkg::WIN_W-1:0]    window_limit;
  logic [swrl_pkg::MAXMSG_W-1:0] message_cap;

  // Predicted result words, oldest first
  admission_t admission_q [$];
  admission_t want;
  admission_t fresh;

  // Expire old stamps, then admit or throttle the request stamped now
  function automatic admission_t predict_admission(swrl_pkg::time_word_t now);
    admission_t           res;
    int unsigned          cap;
    swrl_pkg::time_word_t age;
    bit                   expiring;
    cap = (message_cap > RING_DEPTH) ? RING_DEPTH : message_cap;
    expiring = 1'b1;
    while (expiring && log_count != 0) begin
      age = now - stamp_log[log_head];
      if (age > swrl_pkg::time_word_t'(window_limit)) begin
        log_head = (log_head + 1) % RING_DEPTH;
        log_count--;
      end else begin
        expiring = 1'b0;
      end
    end
    if (log_count >= cap) begin
      res.throttled = 1'b1;
    end else begin
      stamp_log[(log_head + log_count) % RING_DEPTH] = now;
      log_count++;
      res.throttled = 1'b0;
    end
    res.occupancy = swrl_pkg::OCC_W'(log_count);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      log_head     = 0;
      log_count    = 0;
      window_limit = swrl_pkg::WINDOW_RESET;
      message_cap  = swrl_pkg::MAXMSG_RESET;
      admission_q.delete();
    end else begin
      // Compare a delivered result word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (admission_q.size() == 0) begin
          $display("%0t: unexpected result word, throttled %0d occupancy %0d",
                   $time, throttled, occupancy);
          mismatches++;
        end else begin
          want = admission_q[0];
          admission_q.delete(0);
          if (throttled !== want.throttled) begin
            $display("%0t: throttled expected %0d actual %0d",
                     $time, want.throttled, throttled);
            mismatches++;
          end
          if (occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d",
                     $time, want.occupancy, occupancy);
            mismatches++;
          end
        end
      end
      // Track register writes; unmapped indexes are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          swrl_pkg::REG_WINDOW_TICKS: window_limit = cfg_data[swrl_pkg::WIN_W-1:0];
          swrl_pkg::REG_MAX_MESSAGES: message_cap  = cfg_data[swrl_pkg::MAXMSG_W-1:0];
          default: ;
        endcase
      end
      // Predict the result of an accepted request word
      if (in_valid && !in_stall) begin
        fresh       = predict_admission(arrival_time);
        admission_q = {admission_q, fresh};
      end
    end
    outstanding = admission_q.size();
  end

endmodule

// ----- tb/sliding_window_rate_limiter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_tb : top level of the rate limiter testbench
// Drives request words in random bursts, stalls the result channel on a
// changing pattern and reprograms window and limit between phases, from
// the extremes to random settings. The checker beside the block predicts
// every result; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter_tb;

  localparam int unsigned RING_DEPTH   = 64;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 45;
  localparam int unsigned DRAIN_CYCLES = 80;

  // Indexes outside the register map
  localparam logic [swrl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [swrl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  logic [swrl_pkg::TIME_W-1:0]     arrival_time = '0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  logic                            throttled;
  logic [swrl_pkg::OCC_W-1:0]      occupancy;
  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  int                              mismatches;
  int                              outstanding;

  int unsigned                   burst_left = 0;
  swrl_pkg::time_word_t          tick;
  logic [swrl_pkg::WIN_W-1:0]    win;
  logic [swrl_pkg::MAXMSG_W-1:0] cap;
  int unsigned                   eff_cap;
  int unsigned                   span;
  int unsigned                   run_len;
  int unsigned                   placed;
  int unsigned                   pick;
  stall_mode_t                   stall_mode = STALL_NONE;
  int unsigned                   mode_left  = 0;

  always #6 clk = ~clk;

  sliding_window_rate_limiter #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .arrival_time (arrival_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .throttled    (throttled),
    .occupancy    (occupancy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  swrl_checker #(.RING_DEPTH(RING_DEPTH)) admission_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .arrival_time (arrival_time),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .throttled    (throttled),
    .occupancy    (occupancy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Stall the result channel, switching to a new random pattern after a random run
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(8, 80);
      end
      mode_left--;
      unique case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((mode_left % 16) < 10);
      endcase
    end
  end

  // Offer one request word; open a new burst with a random gap when due
  task automatic send_request(input swrl_pkg::time_word_t stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = (gap == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    arrival_time <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off until every predicted word has been delivered
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write window and limit with junk in the unused bits, then an unmapped index
  task automatic load_settings(input logic [swrl_pkg::WIN_W-1:0] win_val,
                               input logic [swrl_pkg::MAXMSG_W-1:0] cap_val);
    logic [swrl_pkg::CFG_IDX_W-1:0]  reg_idx [3];
    logic [swrl_pkg::CFG_DATA_W-1:0] reg_val [3];
    reg_idx[0] = swrl_pkg::REG_WINDOW_TICKS;
    reg_val[0] = {1'($urandom_range(0, 1)), win_val};
    reg_idx[1] = swrl_pkg::REG_MAX_MESSAGES;
    reg_val[1] = {25'($urandom), cap_val};
    reg_idx[2] = $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
    reg_val[2] = $urandom;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data  <= reg_val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: window edge, wrap of the tick count, steps backwards
    send_request(32'h0000_0000);
    send_request(32'd1000);
    send_request(32'd1001);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0100);
    send_request(32'hAAAA_AAAA);
    send_request(32'h5555_5555);
    wait_drained();

    // Widest window, limit of one: half-range age expires, age of zero holds
    load_settings('1, 7'd1);
    send_request(32'h0000_0010);
    send_request(32'h0000_0020);
    send_request(32'h8000_0010);
    send_request(32'h8000_000F);
    send_request(32'h8000_000F);
    wait_drained();

    // Limit of zero with window of zero: throttle everything after expiry
    load_settings('0, 7'd0);
    send_request(32'h8000_000F);
    send_request(32'h8000_0010);
    wait_drained();

    // Window of zero: same tick stays, next tick expires
    load_settings('0, 7'd2);
    send_request(32'h0000_0007);
    send_request(32'h0000_0007);
    send_request(32'h0000_0007);
    send_request(32'h0000_0008);
    wait_drained();

    // Random phases, the first few at the extremes of the registers
    tick = $urandom;
    for (int phase = 0; phase < PHASES; phase++) begin
      unique case (phase)
        0: begin win = '1;                          cap = 7'd127;       end
        1: begin win = 31'd1;                       cap = 7'd1;         end
        2: begin win = '0;                          cap = 7'd64;        end
        3: begin win = 31'($urandom_range(1, 50));  cap = '0;           end
        4: begin
          win = swrl_pkg::WINDOW_RESET;
          cap = swrl_pkg::MAXMSG_RESET;
        end
        default: begin
          win = $urandom_range(0, 1) ? 31'($urandom_range(1, 5000)) : 31'($urandom);
          cap = $urandom_range(0, 3) ? 7'($urandom_range(1, 16))
                                     : 7'($urandom_range(0, 127));
        end
      endcase
      load_settings(win, cap);
      eff_cap = (cap > RING_DEPTH) ? RING_DEPTH : cap;
      placed  = 0;
      while (placed < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // Flood within one window: fill the ring and run into the limit
          run_len = $urandom_range(1, eff_cap + 4);
          span    = win / 70;
          repeat (run_len) begin
            tick = tick + $urandom_range(0, span);
            send_request(tick);
          end
        end else if (pick < 9) begin
          // Trickle spaced about one window apart: expire at the boundary
          run_len = $urandom_range(1, 6);
          repeat (run_len) begin
            tick = tick + {1'b0, win} - 32'd1 + $urandom_range(0, 2);
            send_request(tick);
          end
        end else begin
          // Jump to an arbitrary tick, often backwards
          run_len = 1;
          tick    = $urandom;
          send_request(tick);
        end
        placed += run_len;
      end
      wait_drained();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("sliding_window_rate_limiter verification clean");
    end else begin
      $display("sliding_window_rate_limiter verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("sliding_window_rate_limiter verification failed");
    $finish;
  end

endmodule
